[hdl/binomial_lattice_option_pricer_top_macros.svh]
// Assertion macros used by the lattice pricer controller.
`ifndef BINOMIAL_LATTICE_OPTION_PRICER_TOP_MACROS_SVH
`define BINOMIAL_LATTICE_OPTION_PRICER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BLOP_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lattice pricer check failed");

// Consequent must hold in the cycle after the antecedent.
`define BLOP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lattice pricer check failed");

`endif

[hdl/blop_pkg.sv]
// Types, constants and helper functions of the lattice option pricer.
package blop_pkg;

    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
    localparam logic [8:0] STEP_COUNT_RESET = 9'd256;
    localparam logic [2:0] ADDR_STEP_COUNT = 3'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LADDER,
        ST_INIT,
        ST_FOLD,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        PH_MUL,
        PH_AVG,
        PH_DSC,
        PH_WR,
        PH_CAP
    } phase_t;

    // Strobes from the controller to every cell of the chain.
    typedef struct packed {
        logic load;
        logic mul;
        logic avg;
        logic dsc;
        logic wr;
    } cell_ctl_t;

    // Strobes from the controller to the top-level datapath.
    typedef struct packed {
        logic take;
        logic ladder_start;
        logic tap_shift;
        logic cap_l2;
        logic cap_l1;
        logic cap_root;
        logic out_load;
    } top_ctl_t;

    function automatic logic [31:0] intrinsic(input logic [31:0] s, input logic [31:0] k,
                                              input logic put);
        logic [31:0] r;
        begin
            if (put)
            begin
                r = (k > s) ? (k - s) : 32'd0;
            end
            else
            begin
                r = (s > k) ? (s - k) : 32'd0;
            end
            return r;
        end
    endfunction

    // Saturates a 34-bit rounded product to 32 bits.
    function automatic logic [31:0] sat32(input logic [33:0] v);
        logic [31:0] r;
        begin
            r = (v[33:32] != 2'd0) ? MAX32 : v[31:0];
            return r;
        end
    endfunction

endpackage

[hdl/blop_ifs.sv]
// Request and result channel interfaces of the lattice option pricer.
interface blop_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] spot_price;
    logic [31:0] strike_price;
    logic        is_put;
    logic        american;
    logic        intrinsic_only;
    logic [31:0] up_factor;
    logic [31:0] down_factor;
    logic [31:0] up_probability;
    logic [31:0] discount;

    modport source (
        output valid, spot_price, strike_price, is_put, american, intrinsic_only,
               up_factor, down_factor, up_probability, discount,
        input  ready
    );
    modport sink (
        input  valid, spot_price, strike_price, is_put, american, intrinsic_only,
               up_factor, down_factor, up_probability, discount,
        output ready
    );
endinterface

interface blop_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] root_value;
    logic [31:0] value_up;
    logic [31:0] value_down;
    logic [31:0] value_up_up;
    logic [31:0] value_up_down;
    logic [31:0] value_down_down;

    modport source (
        output valid, root_value, value_up, value_down, value_up_up, value_up_down,
               value_down_down,
        input  ready
    );
    modport sink (
        input  valid, root_value, value_up, value_down, value_up_up, value_up_down,
               value_down_down,
        output ready
    );
endinterface

[hdl/binomial_lattice_option_pricer_top.sv]
// Top level of the Cox-Ross-Rubinstein binomial lattice option pricer.
//
// Prices one option per request on an N-step lattice (N from step_count, clamped to
// 1..MAX_STEPS). A request first builds the up and down price ladders with one shared
// pair of multipliers, then loads the terminal payoffs into the chain of cells. Then
// each lattice level runs the multiply, average, discount and write-back stages in
// every cell, followed by a capture stage into the result registers. The result is
// then handed to the output register, after which the next request can be accepted.
// An intrinsic-only request skips the ladder and the level folds. A new request is
// taken once the previous one has reached the output register, so one result may
// wait there while the next request runs.
module binomial_lattice_option_pricer_top
    import blop_pkg::*;
#(
    parameter int MAX_STEPS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    blop_in_if.sink     in_ch,
    blop_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NW = $clog2(MAX_STEPS + 1);
    localparam int NT = 2 * MAX_STEPS + 1;

    logic [8:0]    step_count_reg;
    logic [NW-1:0] n_clamped;
    logic [NW-1:0] n_reg;
    logic [31:0]   strike_reg;
    logic          put_reg;
    logic          amer_reg;
    logic [31:0]   u_reg;
    logic [31:0]   d_reg;
    logic [31:0]   p_reg;
    logic [31:0]   q_reg;
    logic [31:0]   disc_reg;
    logic [31:0]   p_clamped;

    logic [31:0]   taps_reg [NT];
    logic [31:0]   vals [MAX_STEPS + 1];

    logic [31:0]   res_root_reg, res_u_reg, res_d_reg, res_uu_reg, res_ud_reg, res_dd_reg;
    logic          out_valid_reg;
    logic [31:0]   out_root_reg, out_u_reg, out_d_reg, out_uu_reg, out_ud_reg, out_dd_reg;

    logic          ldr_push;
    logic          ldr_done;
    logic [31:0]   ldr_up;
    logic [31:0]   ldr_dn;
    logic          out_free;
    top_ctl_t      tctl;
    cell_ctl_t     cctl;
    logic [NW:0]   n_ext;
    logic [NW:0]   two_n;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_STEP_COUNT) ? {23'd0, step_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg <= STEP_COUNT_RESET;
        end
        else if (psel && penable && pwrite && paddr == ADDR_STEP_COUNT)
        begin
            step_count_reg <= pwdata[8:0];
        end
    end

    always_comb
    begin
        if (step_count_reg == 9'd0)
        begin
            n_clamped = NW'(1);
        end
        else if (32'(step_count_reg) > 32'(MAX_STEPS))
        begin
            n_clamped = NW'(MAX_STEPS);
        end
        else
        begin
            n_clamped = NW'(step_count_reg);
        end
    end

    assign p_clamped = (in_ch.up_probability > ONE_Q31) ? ONE_Q31 : in_ch.up_probability;

    always_ff @(posedge clk)
    begin
        if (tctl.take)
        begin
            n_reg      <= n_clamped;
            strike_reg <= in_ch.strike_price;
            put_reg    <= in_ch.is_put;
            amer_reg   <= in_ch.american;
            u_reg      <= in_ch.up_factor;
            d_reg      <= in_ch.down_factor;
            p_reg      <= p_clamped;
            q_reg      <= ONE_Q31 - p_clamped;
            disc_reg   <= in_ch.discount;
        end
    end

    blop_ctrl #(
        .NW (NW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_flat     (in_ch.intrinsic_only),
        .ladder_done (ldr_done),
        .out_free    (out_free),
        .n           (n_reg),
        .in_ready    (in_ch.ready),
        .tctl        (tctl),
        .cctl        (cctl)
    );

    blop_ldr #(
        .NW (NW)
    ) u_ldr (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (tctl.ladder_start),
        .spot        (in_ch.spot_price),
        .up_factor   (u_reg),
        .down_factor (d_reg),
        .n           (n_reg),
        .push        (ldr_push),
        .done        (ldr_done),
        .up_price    (ldr_up),
        .dn_price    (ldr_dn)
    );

    // Price taps hold spot*u^(j-N) above the center tap N and spot*d^(N-j) below it. Down
    // prices enter at tap 0 and up prices at tap 2N, both moving inward, so the deepest power
    // lands outermost. Each fold level shifts the taps down by one, so cell i always reads tap 2i.
    assign n_ext = {1'b0, n_reg};
    assign two_n = {n_reg, 1'b0};

    for (genvar j = 0; j < NT; j++)
    begin : g_tap
        always_ff @(posedge clk)
        begin
            if (tctl.take)
            begin
                if ((NW + 1)'(j) == {1'b0, n_clamped})
                begin
                    taps_reg[j] <= in_ch.spot_price;
                end
            end
            else if (ldr_push)
            begin
                if ((NW + 1)'(j) < n_ext)
                begin
                    if (j == 0)
                    begin
                        taps_reg[j] <= ldr_dn;
                    end
                    else
                    begin
                        taps_reg[j] <= taps_reg[(j > 0) ? j - 1 : 0];
                    end
                end
                else if ((NW + 1)'(j) == two_n)
                begin
                    taps_reg[j] <= ldr_up;
                end
                else if ((NW + 1)'(j) > n_ext && (NW + 1)'(j) < two_n)
                begin
                    taps_reg[j] <= taps_reg[(j < NT - 1) ? j + 1 : j];
                end
            end
            else if (tctl.tap_shift)
            begin
                taps_reg[j] <= (j < NT - 1) ? taps_reg[(j < NT - 1) ? j + 1 : j] : 32'd0;
            end
        end
    end

    for (genvar i = 0; i <= MAX_STEPS; i++)
    begin : g_cell
        blop_cell u_cell (
            .clk      (clk),
            .ctl      (cctl),
            .strike   (strike_reg),
            .is_put   (put_reg),
            .american (amer_reg),
            .prob     (p_reg),
            .qprob    (q_reg),
            .disc     (disc_reg),
            .price    (taps_reg[2 * i]),
            .v_up     ((i < MAX_STEPS) ? vals[(i < MAX_STEPS) ? i + 1 : i] : 32'd0),
            .v        (vals[i])
        );
    end

    // Result capture: cleared per request so unreached levels read zero.
    always_ff @(posedge clk)
    begin
        if (tctl.take)
        begin
            res_root_reg <= in_ch.intrinsic_only
                          ? intrinsic(in_ch.spot_price, in_ch.strike_price, in_ch.is_put)
                          : 32'd0;
            res_u_reg    <= 32'd0;
            res_d_reg    <= 32'd0;
            res_uu_reg   <= 32'd0;
            res_ud_reg   <= 32'd0;
            res_dd_reg   <= 32'd0;
        end
        else
        begin
            if (tctl.cap_l2)
            begin
                res_uu_reg <= vals[2];
                res_ud_reg <= vals[1];
                res_dd_reg <= vals[0];
            end
            if (tctl.cap_l1)
            begin
                res_u_reg <= vals[1];
                res_d_reg <= vals[0];
            end
            if (tctl.cap_root)
            begin
                res_root_reg <= vals[0];
            end
        end
    end

    assign out_free = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (tctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tctl.out_load)
        begin
            out_root_reg <= res_root_reg;
            out_u_reg    <= res_u_reg;
            out_d_reg    <= res_d_reg;
            out_uu_reg   <= res_uu_reg;
            out_ud_reg   <= res_ud_reg;
            out_dd_reg   <= res_dd_reg;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.root_value      = out_root_reg;
    assign out_ch.value_up        = out_u_reg;
    assign out_ch.value_down      = out_d_reg;
    assign out_ch.value_up_up     = out_uu_reg;
    assign out_ch.value_up_down   = out_ud_reg;
    assign out_ch.value_down_down = out_dd_reg;

endmodule

[hdl/blop_ldr.sv]
// Price ladder generator: spot*u^k and spot*d^k, each step a multiply followed by a rounded write-back.
module blop_ldr
    import blop_pkg::*;
#(
    parameter int NW = 9
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [31:0]   spot,
    input  logic [31:0]   up_factor,
    input  logic [31:0]   down_factor,
    input  logic [NW-1:0] n,
    output logic          push,
    output logic          done,
    output logic [31:0]   up_price,
    output logic [31:0]   dn_price
);

    logic          busy_reg, busy_next;
    logic          half_reg, half_next;
    logic          push_reg, push_next;
    logic          done_reg, done_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic [63:0]   prod_up_reg;
    logic [63:0]   prod_dn_reg;
    logic [31:0]   up_reg;
    logic [31:0]   dn_reg;
    logic [63:0]   rnd_up;
    logic [63:0]   rnd_dn;

    assign rnd_up = prod_up_reg + 64'h2000_0000;
    assign rnd_dn = prod_dn_reg + 64'h2000_0000;

    always_comb
    begin
        busy_next = busy_reg;
        half_next = half_reg;
        push_next = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            half_next = 1'b0;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            half_next = !half_reg;
            if (half_reg)
            begin
                push_next = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg + 1'b1 == n)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            half_reg <= 1'b0;
            push_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            half_reg <= half_next;
            push_reg <= push_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            up_reg <= spot;
            dn_reg <= spot;
        end
        else if (busy_reg && !half_reg)
        begin
            prod_up_reg <= 64'(up_reg) * 64'(up_factor);
            prod_dn_reg <= 64'(dn_reg) * 64'(down_factor);
        end
        else if (busy_reg)
        begin
            up_reg <= sat32(rnd_up[63:30]);
            dn_reg <= sat32(rnd_dn[63:30]);
        end
    end

    assign push     = push_reg;
    assign done     = done_reg;
    assign up_price = up_reg;
    assign dn_price = dn_reg;

endmodule

[hdl/blop_cell.sv]
// One lattice node: holds its value and folds it with its upper neighbor each level.
module blop_cell
    import blop_pkg::*;
(
    input  logic        clk,
    input  cell_ctl_t   ctl,
    input  logic [31:0] strike,
    input  logic        is_put,
    input  logic        american,
    input  logic [31:0] prob,
    input  logic [31:0] qprob,
    input  logic [31:0] disc,
    input  logic [31:0] price,
    input  logic [31:0] v_up,
    output logic [31:0] v
);

    logic [31:0] v_reg;
    logic [63:0] pu_reg;
    logic [63:0] pd_reg;
    logic [31:0] avg_reg;
    logic [63:0] dp_reg;
    logic [64:0] sum;
    logic [64:0] rnd;
    logic [31:0] cont;
    logic [31:0] exer;

    assign sum  = 65'(pu_reg) + 65'(pd_reg) + 65'h4000_0000;
    assign rnd  = 65'(dp_reg) + 65'h4000_0000;
    assign cont = sat32(rnd[64:31]);
    assign exer = intrinsic(price, strike, is_put);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            v_reg <= exer;
        end
        else if (ctl.mul)
        begin
            pu_reg <= 64'(prob) * 64'(v_up);
            pd_reg <= 64'(qprob) * 64'(v_reg);
        end
        else if (ctl.avg)
        begin
            // The weights sum to one, so the average never exceeds 32 bits.
            avg_reg <= sum[62:31];
        end
        else if (ctl.dsc)
        begin
            dp_reg <= 64'(avg_reg) * 64'(disc);
        end
        else if (ctl.wr)
        begin
            v_reg <= (american && exer > cont) ? exer : cont;
        end
    end

    assign v = v_reg;

endmodule

[hdl/blop_ctrl.sv]
// Sequencer of the lattice pricer: ladder build, terminal load, level folds, result hand-off.
`include "binomial_lattice_option_pricer_top_macros.svh"

module blop_ctrl
    import blop_pkg::*;
#(
    parameter int NW = 9
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_flat,
    input  logic          ladder_done,
    input  logic          out_free,
    input  logic [NW-1:0] n,
    output logic          in_ready,
    output top_ctl_t      tctl,
    output cell_ctl_t     cctl
);

    state_t        state_reg, state_next;
    phase_t        phase_reg, phase_next;
    logic [NW-1:0] level_reg, level_next;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        level_next = level_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = in_flat ? ST_DONE : ST_LADDER;
                end
            end
            ST_LADDER:
            begin
                if (ladder_done)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                state_next = ST_FOLD;
                phase_next = PH_MUL;
                level_next = n - 1'b1;
            end
            ST_FOLD:
            begin
                case (phase_reg)
                    PH_MUL: phase_next = PH_AVG;
                    PH_AVG: phase_next = PH_DSC;
                    PH_DSC: phase_next = PH_WR;
                    PH_WR:  phase_next = PH_CAP;
                    PH_CAP:
                    begin
                        phase_next = PH_MUL;
                        if (level_reg == '0)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            level_next = level_reg - 1'b1;
                        end
                    end
                    default: phase_next = PH_MUL;
                endcase
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        tctl     = '0;
        cctl     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready          = 1'b1;
                tctl.take         = in_valid;
                tctl.ladder_start = in_valid && !in_flat;
            end
            ST_INIT:
            begin
                cctl.load = 1'b1;
            end
            ST_FOLD:
            begin
                case (phase_reg)
                    PH_MUL:
                    begin
                        cctl.mul       = 1'b1;
                        tctl.tap_shift = 1'b1;
                    end
                    PH_AVG: cctl.avg = 1'b1;
                    PH_DSC: cctl.dsc = 1'b1;
                    PH_WR:  cctl.wr = 1'b1;
                    PH_CAP:
                    begin
                        tctl.cap_l2   = (level_reg == NW'(2));
                        tctl.cap_l1   = (level_reg == NW'(1));
                        tctl.cap_root = (level_reg == '0);
                    end
                    default: cctl = '0;
                endcase
            end
            ST_DONE:
            begin
                tctl.out_load = out_free;
            end
            default: in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_MUL;
            level_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            level_reg <= level_next;
        end
    end

    `BLOP_ASSERT_NEXT(a_take_leaves_idle, in_valid && in_ready, state_reg != ST_IDLE)
    `BLOP_ASSERT_NOW(a_level_in_range, state_reg == ST_FOLD, level_reg < n)
    `BLOP_ASSERT_NEXT(a_last_level_done, state_reg == ST_FOLD && phase_reg == PH_CAP && level_reg == '0, state_reg == ST_DONE)
    `BLOP_ASSERT_NOW(a_ladder_done_in_wait, ladder_done, state_reg == ST_LADDER)

endmodule
